// ===== design/mfds_pkg.sv =====
// shared types, widths and constant tables of the multiple flow direction split
`default_nettype none

package mfds_pkg;

  localparam int HEIGHT_BITS = 32;
  localparam int SHARE_BITS  = 16;
  localparam int DIRS        = 8;
  localparam int HALF_DIRS   = DIRS / 2;
  localparam int CFG_W       = 16;
  localparam int FRAC_BITS   = 16;
  localparam int MANT_W      = 31;
  localparam int MANT_FRAC   = MANT_W - 1;
  localparam int P_FRAC      = 8;
  localparam int E_FRAC      = FRAC_BITS + P_FRAC;
  localparam int LOGN_W      = $clog2(HEIGHT_BITS);
  localparam int LOG_W       = LOGN_W + FRAC_BITS;
  localparam int EXPO_W      = LOG_W + CFG_W + 2;
  localparam int K_W         = EXPO_W - E_FRAC;
  localparam int NORM_W      = (HEIGHT_BITS > MANT_W) ? HEIGHT_BITS : MANT_W;
  localparam int SUM_W       = MANT_W + $clog2(DIRS);
  localparam int SHARE_W     = SHARE_BITS + 1;
  localparam int DIV_W       = SUM_W + SHARE_BITS;
  localparam int DIV_STAGES  = SHARE_BITS + 1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

  typedef logic signed [HEIGHT_BITS-1:0] height_t;
  typedef logic [SHARE_W-1:0] share_t;
  typedef logic [MANT_W-1:0] mant_t;

  typedef struct packed {
    height_t             center_height;
    height_t             north_height;
    height_t             northeast_height;
    height_t             east_height;
    height_t             southeast_height;
    height_t             south_height;
    height_t             southwest_height;
    height_t             west_height;
    height_t             northwest_height;
    logic [DIRS-1:0]     inside_mask;
  } in_t;

  typedef struct packed {
    share_t share_dir0;
    share_t share_dir1;
    share_t share_dir2;
    share_t share_dir3;
    share_t share_dir4;
    share_t share_dir5;
    share_t share_dir6;
    share_t share_dir7;
    logic   no_outflow;
  } out_t;

  // beat valid plus the lanes that carry a positive drop
  typedef struct packed {
    logic            vld;
    logic [DIRS-1:0] pos;
  } ctl_t;

  typedef logic [FRAC_BITS-1:0][MANT_W-1:0] coef_arr_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bt;
    x   = x_in;
    res = '0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bt) begin
        x   = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-j) in Q1.30 for j = 1 .. FRAC_BITS
  function automatic coef_arr_t make_coefs();
    coef_arr_t   t;
    logic [63:0] c;
    c = isqrt64(64'd1 << (2 * MANT_FRAC - 1));
    for (int j = 0; j < FRAC_BITS; j++) begin
      t[j] = c[MANT_W-1:0];
      c    = isqrt64(c << MANT_FRAC);
    end
    return t;
  endfunction

  localparam coef_arr_t EXP_COEF = make_coefs();

endpackage

`default_nettype wire

// ===== design/mfds_log2.sv =====
// pipelined log2 by repeated squaring, one fraction bit per stage, all lanes
`default_nettype none

module mfds_log2 (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         en,
  input  wire mfds_pkg::ctl_t                               in_ctl,
  input  wire logic [mfds_pkg::DIRS-1:0][mfds_pkg::LOGN_W-1:0] in_n,
  input  wire logic [mfds_pkg::DIRS-1:0][mfds_pkg::MANT_W-1:0] in_m,
  output mfds_pkg::ctl_t                                    out_ctl,
  output logic [mfds_pkg::DIRS-1:0][mfds_pkg::LOG_W-1:0]    out_log
);

  mfds_pkg::ctl_t ctl_r   [mfds_pkg::FRAC_BITS];
  mfds_pkg::ctl_t ctl_nxt [mfds_pkg::FRAC_BITS];
  logic [mfds_pkg::DIRS-1:0][mfds_pkg::MANT_W-1:0]    m_r     [mfds_pkg::FRAC_BITS];
  logic [mfds_pkg::DIRS-1:0][mfds_pkg::MANT_W-1:0]    m_nxt   [mfds_pkg::FRAC_BITS];
  logic [mfds_pkg::DIRS-1:0][mfds_pkg::LOGN_W-1:0]    n_r     [mfds_pkg::FRAC_BITS];
  logic [mfds_pkg::DIRS-1:0][mfds_pkg::LOGN_W-1:0]    n_nxt   [mfds_pkg::FRAC_BITS];
  logic [mfds_pkg::DIRS-1:0][mfds_pkg::FRAC_BITS-1:0] frac_r  [mfds_pkg::FRAC_BITS];
  logic [mfds_pkg::DIRS-1:0][mfds_pkg::FRAC_BITS-1:0] frac_nxt[mfds_pkg::FRAC_BITS];

  always_comb begin
    logic [mfds_pkg::MANT_W-1:0]    src_m;
    logic [mfds_pkg::LOGN_W-1:0]    src_n;
    logic [mfds_pkg::FRAC_BITS-1:0] src_f;
    logic [2*mfds_pkg::MANT_W-1:0]  sq;
    logic [mfds_pkg::MANT_W:0]      sh;
    for (int s = 0; s < mfds_pkg::FRAC_BITS; s++) begin
      if (s == 0) ctl_nxt[s] = in_ctl;
      else        ctl_nxt[s] = ctl_r[s-1];
      for (int l = 0; l < mfds_pkg::DIRS; l++) begin
        if (s == 0) begin
          src_m = in_m[l];
          src_n = in_n[l];
          src_f = '0;
        end else begin
          src_m = m_r[s-1][l];
          src_n = n_r[s-1][l];
          src_f = frac_r[s-1][l];
        end
        sq = (2*mfds_pkg::MANT_W)'(src_m) * (2*mfds_pkg::MANT_W)'(src_m);
        sh = sq[mfds_pkg::MANT_FRAC +: mfds_pkg::MANT_W+1];
        // square reached 2.0: emit a one and renormalize
        m_nxt[s][l] = sh[mfds_pkg::MANT_W] ? sh[mfds_pkg::MANT_W:1]
                                           : sh[mfds_pkg::MANT_W-1:0];
        src_f[mfds_pkg::FRAC_BITS-1-s] = sh[mfds_pkg::MANT_W];
        frac_nxt[s][l] = src_f;
        n_nxt[s][l]    = src_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < mfds_pkg::FRAC_BITS; s++) ctl_r[s] <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= m_nxt;
      n_r    <= n_nxt;
      frac_r <= frac_nxt;
    end
  end

  assign out_ctl = ctl_r[mfds_pkg::FRAC_BITS-1];

  always_comb begin
    for (int l = 0; l < mfds_pkg::DIRS; l++) begin
      out_log[l] = {n_r[mfds_pkg::FRAC_BITS-1][l], frac_r[mfds_pkg::FRAC_BITS-1][l]};
    end
  end

endmodule

`default_nettype wire

// ===== design/mfds_exp2.sv =====
// pipelined 2^-e: one conditional constant multiply per fraction bit, then the integer shift
`default_nettype none

module mfds_exp2 (
  input  wire logic                                            clk,
  input  wire logic                                            rst_n,
  input  wire logic                                            en,
  input  wire mfds_pkg::ctl_t                                  in_ctl,
  input  wire logic [mfds_pkg::DIRS-1:0][mfds_pkg::FRAC_BITS-1:0] in_f,
  input  wire logic [mfds_pkg::DIRS-1:0][mfds_pkg::K_W-1:0]       in_k,
  output mfds_pkg::ctl_t                                       out_ctl,
  output logic [mfds_pkg::DIRS-1:0][mfds_pkg::MANT_W-1:0]      out_w
);

  mfds_pkg::ctl_t ctl_r   [mfds_pkg::FRAC_BITS];
  mfds_pkg::ctl_t ctl_nxt [mfds_pkg::FRAC_BITS];
  logic [mfds_pkg::DIRS-1:0][mfds_pkg::MANT_W-1:0]    r_r   [mfds_pkg::FRAC_BITS];
  logic [mfds_pkg::DIRS-1:0][mfds_pkg::MANT_W-1:0]    r_nxt [mfds_pkg::FRAC_BITS];
  logic [mfds_pkg::DIRS-1:0][mfds_pkg::FRAC_BITS-1:0] f_r   [mfds_pkg::FRAC_BITS];
  logic [mfds_pkg::DIRS-1:0][mfds_pkg::FRAC_BITS-1:0] f_nxt [mfds_pkg::FRAC_BITS];
  logic [mfds_pkg::DIRS-1:0][mfds_pkg::K_W-1:0]       k_r   [mfds_pkg::FRAC_BITS];
  logic [mfds_pkg::DIRS-1:0][mfds_pkg::K_W-1:0]       k_nxt [mfds_pkg::FRAC_BITS];
  mfds_pkg::ctl_t                                     octl_r;
  logic [mfds_pkg::DIRS-1:0][mfds_pkg::MANT_W-1:0]    w_r;
  logic [mfds_pkg::DIRS-1:0][mfds_pkg::MANT_W-1:0]    w_nxt;

  always_comb begin
    logic [mfds_pkg::MANT_W-1:0]    src_r;
    logic [mfds_pkg::FRAC_BITS-1:0] src_f;
    logic [mfds_pkg::K_W-1:0]       src_k;
    logic [2*mfds_pkg::MANT_W-1:0]  prod;
    for (int s = 0; s < mfds_pkg::FRAC_BITS; s++) begin
      if (s == 0) ctl_nxt[s] = in_ctl;
      else        ctl_nxt[s] = ctl_r[s-1];
      for (int l = 0; l < mfds_pkg::DIRS; l++) begin
        if (s == 0) begin
          src_r = mfds_pkg::MANT_W'(1) << mfds_pkg::MANT_FRAC;
          src_f = in_f[l];
          src_k = in_k[l];
        end else begin
          src_r = r_r[s-1][l];
          src_f = f_r[s-1][l];
          src_k = k_r[s-1][l];
        end
        prod = (2*mfds_pkg::MANT_W)'(src_r) *
               (2*mfds_pkg::MANT_W)'(mfds_pkg::EXP_COEF[s]);
        r_nxt[s][l] = src_f[mfds_pkg::FRAC_BITS-1-s] ?
                      prod[mfds_pkg::MANT_FRAC +: mfds_pkg::MANT_W] : src_r;
        f_nxt[s][l] = src_f;
        k_nxt[s][l] = src_k;
      end
    end
    for (int l = 0; l < mfds_pkg::DIRS; l++) begin
      if (ctl_r[mfds_pkg::FRAC_BITS-1].pos[l] &&
          k_r[mfds_pkg::FRAC_BITS-1][l] < mfds_pkg::K_W'(mfds_pkg::MANT_W)) begin
        w_nxt[l] = r_r[mfds_pkg::FRAC_BITS-1][l] >> k_r[mfds_pkg::FRAC_BITS-1][l];
      end else begin
        w_nxt[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < mfds_pkg::FRAC_BITS; s++) ctl_r[s] <= '0;
      octl_r <= '0;
    end else if (en) begin
      ctl_r  <= ctl_nxt;
      octl_r <= ctl_r[mfds_pkg::FRAC_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r_nxt;
      f_r <= f_nxt;
      k_r <= k_nxt;
      w_r <= w_nxt;
    end
  end

  assign out_ctl = octl_r;
  assign out_w   = w_r;

endmodule

`default_nettype wire

// ===== design/multiple_flow_direction_split.sv =====
// top level: multiple flow direction split of one 3x3 elevation window per beat
//
// Input channel in_valid/in_stall/in_data carries one window (center, eight
// neighbors clockwise from north, inside-grid mask). Output channel
// out_valid/out_stall/out_data carries eight Q1.16 flow shares and no_outflow.
// cfg_wr_en/cfg_wr_data write the convergence exponent p (Q8.8), reset 1.0;
// write it only while no beat is in flight.
// Throughput: one beat per cycle unless the output stalls. Stage chain from
// input beat to out_valid: drop, leading one, normalize, 16 squaring
// stages for log2, exponent multiply, three-level max tree, difference,
// 16 multiply stages plus a shift for exp2, three-level adder tree, 17
// restoring divide stages and the output register.
// Reset (rst_n low, synchronous) empties every stage and the output register.
// When the receiver stalls a held result, the pipeline keeps moving until its
// last stage holds a beat; only then in_stall rises, so nothing is dropped.
`default_nettype none

module multiple_flow_direction_split (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire mfds_pkg::in_t               in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output mfds_pkg::out_t                   out_data,
  input  wire logic                        cfg_wr_en,
  input  wire logic [mfds_pkg::CFG_W-1:0]  cfg_wr_data
);

  localparam int D = mfds_pkg::DIRS;

  logic [mfds_pkg::CFG_W-1:0] cfg_r;
  logic                       en;
  logic                       out_load;
  logic                       out_vld_r;
  mfds_pkg::out_t             out_data_r;
  mfds_pkg::out_t             out_data_nxt;

  mfds_pkg::height_t hgt [D];

  // drop, leading one, normalize
  mfds_pkg::ctl_t ctl1_r, ctl1_nxt, ctl2_r, ctl3_r;
  logic [D-1:0][mfds_pkg::HEIGHT_BITS-1:0] drop1_r, drop1_nxt, drop2_r;
  logic [D-1:0][mfds_pkg::LOGN_W-1:0]      n2_nxt, n2_r, n3_r;
  logic [D-1:0][mfds_pkg::MANT_W-1:0]      m3_nxt, m3_r;

  mfds_pkg::ctl_t                          lg_ctl;
  logic [D-1:0][mfds_pkg::LOG_W-1:0]       lg_log;

  // exponent and max tree
  mfds_pkg::ctl_t ctl4_r, ctl5_r, ctl6_r, ctl7_r, ctl8_r;
  logic signed [mfds_pkg::EXPO_W-1:0] a4_nxt [D];
  logic signed [mfds_pkg::EXPO_W-1:0] a4_r [D];
  logic signed [mfds_pkg::EXPO_W-1:0] a5_r [D];
  logic signed [mfds_pkg::EXPO_W-1:0] a6_r [D];
  logic signed [mfds_pkg::EXPO_W-1:0] a7_r [D];
  logic signed [mfds_pkg::EXPO_W-1:0] mx5_nxt [D/2];
  logic signed [mfds_pkg::EXPO_W-1:0] mx5_r [D/2];
  logic signed [mfds_pkg::EXPO_W-1:0] mx6_nxt [D/4];
  logic signed [mfds_pkg::EXPO_W-1:0] mx6_r [D/4];
  logic signed [mfds_pkg::EXPO_W-1:0] mx7_nxt;
  logic signed [mfds_pkg::EXPO_W-1:0] mx7_r;
  logic [D/2-1:0] mv5_nxt, mv5_r;
  logic [D/4-1:0] mv6_nxt, mv6_r;
  logic [D-1:0][mfds_pkg::FRAC_BITS-1:0] f8_nxt, f8_r;
  logic [D-1:0][mfds_pkg::K_W-1:0]       k8_nxt, k8_r;

  mfds_pkg::ctl_t                          ex_ctl;
  logic [D-1:0][mfds_pkg::MANT_W-1:0]      ex_w;

  // adder tree
  mfds_pkg::ctl_t ctl9_r, ctl10_r, ctl11_r;
  logic [D-1:0][mfds_pkg::MANT_W-1:0]   w9_r, w10_r, w11_r;
  logic [D/2-1:0][mfds_pkg::MANT_W:0]   s9_nxt, s9_r;
  logic [D/4-1:0][mfds_pkg::MANT_W+1:0] s10_nxt, s10_r;
  logic [mfds_pkg::SUM_W-1:0]           s11_nxt, s11_r;

  // divider
  mfds_pkg::ctl_t dctl_r   [mfds_pkg::DIV_STAGES];
  mfds_pkg::ctl_t dctl_nxt [mfds_pkg::DIV_STAGES];
  logic [mfds_pkg::SUM_W-1:0]               dsum_r   [mfds_pkg::DIV_STAGES];
  logic [mfds_pkg::SUM_W-1:0]               dsum_nxt [mfds_pkg::DIV_STAGES];
  logic [D-1:0][mfds_pkg::DIV_W-1:0]        rem_r    [mfds_pkg::DIV_STAGES];
  logic [D-1:0][mfds_pkg::DIV_W-1:0]        rem_nxt  [mfds_pkg::DIV_STAGES];
  logic [D-1:0][mfds_pkg::SHARE_W-1:0]      q_r      [mfds_pkg::DIV_STAGES];
  logic [D-1:0][mfds_pkg::SHARE_W-1:0]      q_nxt    [mfds_pkg::DIV_STAGES];

  // flow control: the whole chain moves unless a finished beat is blocked
  assign out_load = !out_vld_r || !out_stall;
  assign en       = out_load || !dctl_r[mfds_pkg::DIV_STAGES-1].vld;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= mfds_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  assign hgt[0] = in_data.north_height;
  assign hgt[1] = in_data.northeast_height;
  assign hgt[2] = in_data.east_height;
  assign hgt[3] = in_data.southeast_height;
  assign hgt[4] = in_data.south_height;
  assign hgt[5] = in_data.southwest_height;
  assign hgt[6] = in_data.west_height;
  assign hgt[7] = in_data.northwest_height;

  // front end: drop with edge mirroring, leading one, mantissa alignment
  always_comb begin
    logic signed [mfds_pkg::HEIGHT_BITS:0] c_x;
    logic signed [mfds_pkg::HEIGHT_BITS:0] d;
    logic [mfds_pkg::NORM_W-1:0]           nm;
    int                                    opp;
    c_x = {in_data.center_height[mfds_pkg::HEIGHT_BITS-1], in_data.center_height};
    ctl1_nxt.vld = in_valid;
    for (int l = 0; l < D; l++) begin
      opp = (l + mfds_pkg::HALF_DIRS) % D;
      if (in_data.inside_mask[l]) begin
        d = c_x - {hgt[l][mfds_pkg::HEIGHT_BITS-1], hgt[l]};
      end else if (in_data.inside_mask[opp]) begin
        d = {hgt[opp][mfds_pkg::HEIGHT_BITS-1], hgt[opp]} - c_x;
      end else begin
        d = '0;
      end
      ctl1_nxt.pos[l] = !d[mfds_pkg::HEIGHT_BITS] && (d != '0);
      drop1_nxt[l]    = d[mfds_pkg::HEIGHT_BITS-1:0];

      n2_nxt[l] = '0;
      for (int b = 0; b < mfds_pkg::HEIGHT_BITS; b++) begin
        if (drop1_r[l][b]) n2_nxt[l] = mfds_pkg::LOGN_W'(b);
      end

      nm = mfds_pkg::NORM_W'(drop2_r[l]) << (mfds_pkg::NORM_W - 1 - int'(n2_r[l]));
      m3_nxt[l] = nm[mfds_pkg::NORM_W-1 -: mfds_pkg::MANT_W];
    end
  end

  mfds_log2 u_log2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_ctl  (ctl3_r),
    .in_n    (n3_r),
    .in_m    (m3_r),
    .out_ctl (lg_ctl),
    .out_log (lg_log)
  );

  // exponent, max over positive lanes, distance from the max
  always_comb begin
    logic signed [mfds_pkg::LOG_W:0]   lsig;
    logic signed [mfds_pkg::CFG_W:0]   psig;
    logic signed [mfds_pkg::EXPO_W:0]  dif;
    logic [mfds_pkg::EXPO_W-1:0]       eu;
    psig = $signed({1'b0, cfg_r});
    for (int l = 0; l < D; l++) begin
      lsig = $signed({1'b0, lg_log[l]});
      // diagonal lanes divide the drop by sqrt2
      if (l % 2 == 1) lsig = lsig - (mfds_pkg::LOG_W+1)'(1 << (mfds_pkg::FRAC_BITS - 1));
      a4_nxt[l] = lsig * psig;
    end
    for (int j = 0; j < D/2; j++) begin
      mv5_nxt[j] = ctl4_r.pos[2*j] | ctl4_r.pos[2*j+1];
      mx5_nxt[j] = (ctl4_r.pos[2*j] && (!ctl4_r.pos[2*j+1] || a4_r[2*j] >= a4_r[2*j+1]))
                   ? a4_r[2*j] : a4_r[2*j+1];
    end
    for (int j = 0; j < D/4; j++) begin
      mv6_nxt[j] = mv5_r[2*j] | mv5_r[2*j+1];
      mx6_nxt[j] = (mv5_r[2*j] && (!mv5_r[2*j+1] || mx5_r[2*j] >= mx5_r[2*j+1]))
                   ? mx5_r[2*j] : mx5_r[2*j+1];
    end
    mx7_nxt = (mv6_r[0] && (!mv6_r[1] || mx6_r[0] >= mx6_r[1])) ? mx6_r[0] : mx6_r[1];
    for (int l = 0; l < D; l++) begin
      dif       = mx7_r - a7_r[l];
      eu        = dif[mfds_pkg::EXPO_W-1:0];
      f8_nxt[l] = eu[mfds_pkg::E_FRAC-1 -: mfds_pkg::FRAC_BITS];
      k8_nxt[l] = eu[mfds_pkg::EXPO_W-1:mfds_pkg::E_FRAC];
    end
  end

  mfds_exp2 u_exp2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_ctl  (ctl8_r),
    .in_f    (f8_r),
    .in_k    (k8_r),
    .out_ctl (ex_ctl),
    .out_w   (ex_w)
  );

  // weight sum and restoring division, one quotient bit per stage
  always_comb begin
    logic [mfds_pkg::DIV_W-1:0]   src_rem;
    logic [mfds_pkg::SHARE_W-1:0] src_q;
    logic [mfds_pkg::SUM_W-1:0]   src_sum;
    logic [mfds_pkg::DIV_W-1:0]   sub;
    for (int j = 0; j < D/2; j++) begin
      s9_nxt[j] = (mfds_pkg::MANT_W+1)'(ex_w[2*j]) + (mfds_pkg::MANT_W+1)'(ex_w[2*j+1]);
    end
    for (int j = 0; j < D/4; j++) begin
      s10_nxt[j] = (mfds_pkg::MANT_W+2)'(s9_r[2*j]) + (mfds_pkg::MANT_W+2)'(s9_r[2*j+1]);
    end
    s11_nxt = mfds_pkg::SUM_W'(s10_r[0]) + mfds_pkg::SUM_W'(s10_r[1]);

    for (int s = 0; s < mfds_pkg::DIV_STAGES; s++) begin
      if (s == 0) begin
        dctl_nxt[s] = ctl11_r;
        src_sum     = s11_r;
      end else begin
        dctl_nxt[s] = dctl_r[s-1];
        src_sum     = dsum_r[s-1];
      end
      dsum_nxt[s] = src_sum;
      sub = mfds_pkg::DIV_W'(src_sum) << (mfds_pkg::SHARE_BITS - s);
      for (int l = 0; l < D; l++) begin
        if (s == 0) begin
          src_rem = mfds_pkg::DIV_W'(w11_r[l]) << mfds_pkg::SHARE_BITS;
          src_q   = '0;
        end else begin
          src_rem = rem_r[s-1][l];
          src_q   = q_r[s-1][l];
        end
        if (src_rem >= sub) begin
          src_rem = src_rem - sub;
          src_q[mfds_pkg::SHARE_BITS-s] = 1'b1;
        end
        rem_nxt[s][l] = src_rem;
        q_nxt[s][l]   = src_q;
      end
    end
  end

  always_comb begin
    logic                                any;
    logic [D-1:0][mfds_pkg::SHARE_W-1:0] sh;
    any = |dctl_r[mfds_pkg::DIV_STAGES-1].pos;
    for (int l = 0; l < D; l++) begin
      sh[l] = any ? q_r[mfds_pkg::DIV_STAGES-1][l] : '0;
    end
    out_data_nxt.share_dir0 = sh[0];
    out_data_nxt.share_dir1 = sh[1];
    out_data_nxt.share_dir2 = sh[2];
    out_data_nxt.share_dir3 = sh[3];
    out_data_nxt.share_dir4 = sh[4];
    out_data_nxt.share_dir5 = sh[5];
    out_data_nxt.share_dir6 = sh[6];
    out_data_nxt.share_dir7 = sh[7];
    out_data_nxt.no_outflow = !any;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r  <= '0;
      ctl2_r  <= '0;
      ctl3_r  <= '0;
      ctl4_r  <= '0;
      ctl5_r  <= '0;
      ctl6_r  <= '0;
      ctl7_r  <= '0;
      ctl8_r  <= '0;
      ctl9_r  <= '0;
      ctl10_r <= '0;
      ctl11_r <= '0;
      for (int s = 0; s < mfds_pkg::DIV_STAGES; s++) dctl_r[s] <= '0;
    end else if (en) begin
      ctl1_r  <= ctl1_nxt;
      ctl2_r  <= ctl1_r;
      ctl3_r  <= ctl2_r;
      ctl4_r  <= lg_ctl;
      ctl5_r  <= ctl4_r;
      ctl6_r  <= ctl5_r;
      ctl7_r  <= ctl6_r;
      ctl8_r  <= ctl7_r;
      ctl9_r  <= ex_ctl;
      ctl10_r <= ctl9_r;
      ctl11_r <= ctl10_r;
      dctl_r  <= dctl_nxt;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      drop1_r <= drop1_nxt;
      drop2_r <= drop1_r;
      n2_r    <= n2_nxt;
      n3_r    <= n2_r;
      m3_r    <= m3_nxt;
      a4_r    <= a4_nxt;
      a5_r    <= a4_r;
      a6_r    <= a5_r;
      a7_r    <= a6_r;
      mx5_r   <= mx5_nxt;
      mv5_r   <= mv5_nxt;
      mx6_r   <= mx6_nxt;
      mv6_r   <= mv6_nxt;
      mx7_r   <= mx7_nxt;
      f8_r    <= f8_nxt;
      k8_r    <= k8_nxt;
      w9_r    <= ex_w;
      w10_r   <= w9_r;
      w11_r   <= w10_r;
      s9_r    <= s9_nxt;
      s10_r   <= s10_nxt;
      s11_r   <= s11_nxt;
      dsum_r  <= dsum_nxt;
      rem_r   <= rem_nxt;
      q_r     <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= dctl_r[mfds_pkg::DIV_STAGES-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== design/mfds_chk.sv =====
// port-level checker for the multiple flow direction split, bound to the top level
`default_nettype none

module mfds_chk (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire mfds_pkg::out_t out_data
);

  logic [mfds_pkg::SHARE_W+2:0] share_sum;

  assign share_sum = (mfds_pkg::SHARE_W+3)'(out_data.share_dir0) +
                     (mfds_pkg::SHARE_W+3)'(out_data.share_dir1) +
                     (mfds_pkg::SHARE_W+3)'(out_data.share_dir2) +
                     (mfds_pkg::SHARE_W+3)'(out_data.share_dir3) +
                     (mfds_pkg::SHARE_W+3)'(out_data.share_dir4) +
                     (mfds_pkg::SHARE_W+3)'(out_data.share_dir5) +
                     (mfds_pkg::SHARE_W+3)'(out_data.share_dir6) +
                     (mfds_pkg::SHARE_W+3)'(out_data.share_dir7);

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_empty_out_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_sink_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.no_outflow |-> share_sum == '0)
    else $error("shares nonzero without outflow");

  a_share_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.no_outflow |->
      share_sum != '0 &&
      share_sum <= ((mfds_pkg::SHARE_W+3)'(1) << mfds_pkg::SHARE_BITS))
    else $error("share total out of range");

endmodule

bind multiple_flow_direction_split mfds_chk u_mfds_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
